@@ rtl/edo_pkg.sv @@
// ----------------------------------------------------------------------------
// edo_pkg
// Shared widths, register codes, reset values and status types for the
// EMA detrend oscillator.
// ----------------------------------------------------------------------------
package edo_pkg;

	localparam int FRAC_W    = 16;
	localparam int PERIOD_W  = 11;
	localparam int ALPHA_W   = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int SUM_W     = 43;
	localparam int EMA_W     = 49;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RST     = 11'd30;
	localparam logic [ALPHA_W-1:0]  ALPHA_RST      = 17'd4228;
	localparam logic [ALPHA_W-1:0]  INV_PERIOD_RST = 17'd2185;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [EMA_W-1:0] EMA_MAX = {1'b0, {(EMA_W-1){1'b1}}};
	localparam logic signed [EMA_W-1:0] EMA_MIN = {1'b1, {(EMA_W-1){1'b0}}};

	typedef struct packed {
		logic leading_seen;
		logic warm_all_valid;
		logic ema_valid;
	} edo_flags_t;

	localparam edo_flags_t FLAGS_CLEAR = '{leading_seen: 1'b0, warm_all_valid: 1'b1,
		ema_valid: 1'b0};

endpackage

@@ rtl/edo_if.sv @@
// ----------------------------------------------------------------------------
// edo_in_if / edo_out_if
// Valid/ready channels for samples in and oscillator results out.
// ----------------------------------------------------------------------------
interface edo_in_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          sample_valid;
	logic                          series_start;

	modport source (output valid, sample, sample_valid, series_start, input ready);
	modport sink   (input valid, sample, sample_valid, series_start, output ready);
endinterface

interface edo_out_if;
	import edo_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [EMA_W-1:0] osc;
	logic                    osc_valid;

	modport source (output valid, osc, osc_valid, input ready);
	modport sink   (input valid, osc, osc_valid, output ready);
endinterface

@@ rtl/edo_step.sv @@
// ----------------------------------------------------------------------------
// edo_step
// Next-state and result logic for one sample: warmup sum, EMA seed,
// EMA update and the saturated oscillator output.
// ----------------------------------------------------------------------------
module edo_step #(
	parameter int SAMPLE_BITS = 32,
	parameter int CNT_W       = 11
) (
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic                              sample_valid,
	input  logic                              series_start,
	input  logic [CNT_W-1:0]                  period_eff,
	input  logic [edo_pkg::ALPHA_W-1:0]       alpha,
	input  logic [edo_pkg::ALPHA_W-1:0]       inv_period,
	input  logic [CNT_W-1:0]                  item_count,
	input  edo_pkg::edo_flags_t               flags,
	input  logic signed [edo_pkg::SUM_W-1:0]  warm_sum,
	input  logic signed [edo_pkg::EMA_W-1:0]  ema,
	output logic [CNT_W-1:0]                  item_count_nx,
	output edo_pkg::edo_flags_t               flags_nx,
	output logic signed [edo_pkg::SUM_W-1:0]  warm_sum_nx,
	output logic signed [edo_pkg::EMA_W-1:0]  ema_nx,
	output logic signed [edo_pkg::EMA_W-1:0]  osc,
	output logic                              osc_valid
);
	import edo_pkg::*;

	localparam int SHW  = SAMPLE_BITS + FRAC_W;
	localparam int DW   = ((SHW > EMA_W) ? SHW : EMA_W) + 1;
	localparam int HPW  = DW + 2;
	localparam int STW  = DW + 3;
	localparam int SPW  = SUM_W + ALPHA_W + 1;

	function automatic logic signed [EMA_W-1:0] sat_ema(input logic signed [63:0] v);
		logic signed [EMA_W-1:0] r;
		if (v > 64'(EMA_MAX))
			r = EMA_MAX;
		else if (v < 64'(EMA_MIN))
			r = EMA_MIN;
		else
			r = EMA_W'(v);
		return r;
	endfunction

	// state as seen by this sample (a series start clears it first)
	logic [CNT_W-1:0]         cnt_e;
	edo_flags_t               flags_e;
	logic signed [SUM_W-1:0]  sum_e;
	logic signed [EMA_W-1:0]  ema_e;

	logic [CNT_W-1:0]         cnt_inc;
	logic signed [SUM_W:0]    sum_raw;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [SPW-1:0]    seed_prod;
	logic signed [EMA_W-1:0]  seed;
	logic signed [SHW-1:0]    s_sh;
	logic signed [DW-1:0]     diff;
	logic signed [DW-FRAC_W-1:0] diff_hi;
	logic signed [HPW-1:0]    hi_prod;
	logic [ALPHA_W+FRAC_W-1:0] lo_prod;
	logic signed [STW-1:0]    step;
	logic signed [STW:0]      upd_raw;
	logic signed [EMA_W-1:0]  upd;
	logic signed [DW-1:0]     osc_raw;
	logic                     res_v;

	assign cnt_e   = series_start ? '0 : item_count;
	assign flags_e = series_start ? FLAGS_CLEAR : flags;
	assign sum_e   = series_start ? '0 : warm_sum;
	assign ema_e   = series_start ? '0 : ema;

	assign cnt_inc = cnt_e + CNT_W'(1);

	assign sum_raw = (SUM_W+1)'(sum_e) + (SUM_W+1)'(sample);
	assign sum_sat = (sum_raw[SUM_W] != sum_raw[SUM_W-1]) ?
		(sum_raw[SUM_W] ? SUM_MIN : SUM_MAX) : sum_raw[SUM_W-1:0];

	assign seed_prod = $signed(sum_sat) * $signed({1'b0, inv_period});
	assign seed      = sat_ema(64'(seed_prod));

	// ema += floor(alpha * diff / 2^16), split into high and low parts of diff
	assign s_sh    = $signed({sample, {FRAC_W{1'b0}}});
	assign diff    = DW'(s_sh) - DW'(ema_e);
	assign diff_hi = diff[DW-1:FRAC_W];
	assign hi_prod = $signed({1'b0, alpha}) * diff_hi;
	assign lo_prod = alpha * diff[FRAC_W-1:0];
	assign step    = STW'(hi_prod) + STW'($signed({1'b0, lo_prod[ALPHA_W+FRAC_W-1:FRAC_W]}));
	assign upd_raw = (STW+1)'(ema_e) + (STW+1)'(step);
	assign upd     = sat_ema(64'(upd_raw));

	always_comb begin
		item_count_nx = cnt_e;
		flags_nx      = flags_e;
		warm_sum_nx   = sum_e;
		ema_nx        = ema_e;
		res_v         = 1'b0;
		flags_nx.leading_seen = 1'b1;
		if (flags_e.leading_seen || sample_valid) begin
			if (cnt_e < period_eff) begin
				item_count_nx = cnt_inc;
				if (sample_valid)
					warm_sum_nx = sum_sat;
				else
					flags_nx.warm_all_valid = 1'b0;
				if (cnt_inc == period_eff && flags_nx.warm_all_valid) begin
					ema_nx             = seed;
					flags_nx.ema_valid = 1'b1;
					res_v              = 1'b1;
				end
			end else if (flags_e.ema_valid && sample_valid) begin
				ema_nx = upd;
				res_v  = 1'b1;
			end
		end
	end

	assign osc_raw   = DW'(s_sh) - DW'(ema_nx);
	assign osc       = res_v ? sat_ema(64'(osc_raw)) : '0;
	assign osc_valid = res_v;

endmodule

@@ rtl/ema_detrend_oscillator_top.sv @@
// ----------------------------------------------------------------------------
// ema_detrend_oscillator_top
// Sample minus its exponential moving average, Q.16, one result per sample.
// ----------------------------------------------------------------------------
// Takes one sample per clock and returns one result per sample, in order. A
// sample is captured in the input register (s1) and its result is loaded into
// the output register when s1 moves on, which waits while an untaken result
// is held; sustained rate is one sample per cycle as long as results are
// taken. The rate is set by the EMA update loop: the 17-bit alpha multiply and
// add feed the EMA register combinationally. Registers (period, alpha_q16,
// inv_period_q16) are to be written only while the block is idle; the block
// itself does not enforce this. The first counted period-1 samples of a
// series give invalid results with osc = 0; an invalid sample heading a series
// is passed through uncounted. No clearing pass is needed after reset.
module ema_detrend_oscillator_top #(
	parameter int PERIOD_MAX  = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [edo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [edo_pkg::CFG_W-1:0]       cfg_data,
	edo_in_if.sink                          in_ch,
	edo_out_if.source                       out_ch
);
	import edo_pkg::*;

	localparam int CNT_W = $clog2(PERIOD_MAX + 1);

	logic [PERIOD_W-1:0] period_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [ALPHA_W-1:0]  inv_period_q;
	logic [CNT_W-1:0]    period_eff;

	logic                          vld_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          sample_valid_s1;
	logic                          series_start_s1;
	logic                          adv_s1;
	logic                          in_xfer;

	logic [CNT_W-1:0]        item_count_q;
	edo_flags_t              flags_q;
	logic signed [SUM_W-1:0] warm_sum_q;
	logic signed [EMA_W-1:0] ema_q;

	logic [CNT_W-1:0]        item_count_nx;
	edo_flags_t              flags_nx;
	logic signed [SUM_W-1:0] warm_sum_nx;
	logic signed [EMA_W-1:0] ema_nx;
	logic signed [EMA_W-1:0] osc_nx;
	logic                    osc_valid_nx;

	logic                    out_vld_q;
	logic signed [EMA_W-1:0] osc_q;
	logic                    osc_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RST;
			alpha_q      <= ALPHA_RST;
			inv_period_q <= INV_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD:     period_q     <= cfg_data[PERIOD_W-1:0];
				REG_ALPHA:      alpha_q      <= cfg_data[ALPHA_W-1:0];
				REG_INV_PERIOD: inv_period_q <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above the maximum as the maximum
	always_comb begin
		if (period_q == '0)
			period_eff = CNT_W'(1);
		else if (32'(period_q) > PERIOD_MAX)
			period_eff = CNT_W'(PERIOD_MAX);
		else
			period_eff = CNT_W'(period_q);
	end

	// handshake: s1 moves on whenever the output register is free or drains
	assign adv_s1      = vld_s1 && (!out_vld_q || out_ch.ready);
	assign in_ch.ready = !vld_s1 || adv_s1;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= in_xfer || (vld_s1 && !adv_s1);
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1       <= in_ch.sample;
			sample_valid_s1 <= in_ch.sample_valid;
			series_start_s1 <= in_ch.series_start;
		end
	end

	edo_step #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CNT_W       (CNT_W)
	) u_step (
		.sample        (sample_s1),
		.sample_valid  (sample_valid_s1),
		.series_start  (series_start_s1),
		.period_eff    (period_eff),
		.alpha         (alpha_q),
		.inv_period    (inv_period_q),
		.item_count    (item_count_q),
		.flags         (flags_q),
		.warm_sum      (warm_sum_q),
		.ema           (ema_q),
		.item_count_nx (item_count_nx),
		.flags_nx      (flags_nx),
		.warm_sum_nx   (warm_sum_nx),
		.ema_nx        (ema_nx),
		.osc           (osc_nx),
		.osc_valid     (osc_valid_nx)
	);

	// series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= '0;
			flags_q      <= FLAGS_CLEAR;
			warm_sum_q   <= '0;
			ema_q        <= '0;
		end else if (adv_s1) begin
			item_count_q <= item_count_nx;
			flags_q      <= flags_nx;
			warm_sum_q   <= warm_sum_nx;
			ema_q        <= ema_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else
			out_vld_q <= adv_s1 || (out_vld_q && !out_ch.ready);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			osc_q       <= osc_nx;
			osc_valid_q <= osc_valid_nx;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.osc       = osc_q;
	assign out_ch.osc_valid = osc_valid_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_count_q <= CNT_W'(PERIOD_MAX))
		else $error("item count beyond PERIOD_MAX");

	a_ema_needs_lead: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.ema_valid |-> flags_q.leading_seen)
		else $error("EMA valid without a leading sample");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(ema_q) && $stable(item_count_q) && $stable(warm_sum_q))
		else $error("series state changed without a sample moving on");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !osc_valid_q |-> osc_q == '0)
		else $error("invalid result carries a nonzero osc");

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> vld_s1)
		else $error("accepted sample lost before s1");
`endif

endmodule
